@@ src/rbw_pkg.sv @@
// Package for the reflecting box wall thermostat.
// Holds field widths, register indexes, limits and the structs that travel down the pipeline.
// Depends on nothing.
`default_nettype none

package rbw_pkg;

   localparam int unsigned AXES      = 3;
   localparam int unsigned POS_W     = 31;
   localparam int unsigned MOVE_W    = 32;
   localparam int unsigned VEL_W     = 32;
   localparam int unsigned MASS_W    = 31;
   localparam int unsigned CFG_W     = 31;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned KT_W      = 2 * CFG_W;
   localparam int unsigned P_W       = 64;
   localparam int unsigned SUM_W     = 64;
   localparam int unsigned SPEED_W   = 31;
   localparam int unsigned LEN_W     = 32;
   localparam int unsigned PROD_W    = VEL_W + SPEED_W;

   localparam logic [CFG_W-1:0]   CFG_RESET = 31'd65536;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 31'h7FFF_FFFF;
   localparam logic [VEL_W-1:0]   VEL_MAX   = 32'h7FFF_FFFF;
   localparam logic [VEL_W-1:0]   VEL_MIN   = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_SIZE_X   = 3'd0,
      CSR_BOX_SIZE_Y   = 3'd1,
      CSR_BOX_SIZE_Z   = 3'd2,
      CSR_BOLTZMANN    = 3'd3,
      CSR_TEMPERATURE  = 3'd4
   } rbw_csr_type;

   typedef struct packed {
      logic [AXES-1:0][POS_W-1:0] pos;
      logic [AXES-1:0]            neg;
      logic [AXES-1:0][VEL_W-1:0] mag;
      logic                       hit;
   } rbw_kin_type;

   typedef struct packed {
      rbw_kin_type      kin;
      logic [SUM_W-1:0] sum;
      logic             sat;
   } rbw_speed_tag_type;

   typedef struct packed {
      rbw_kin_type        kin;
      logic [SPEED_W-1:0] speed;
   } rbw_len_tag_type;

   typedef struct packed {
      rbw_kin_type kin;
      logic        rescale;
   } rbw_quot_tag_type;

endpackage

`default_nettype wire

@@ src/rbw_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with several numerator lanes
// sharing one divisor and a side tag that travels with each beat. Self-contained.
`default_nettype none

module rbw_divider #(
   parameter int unsigned QUO_W = 32,
   parameter int unsigned DEN_W = 32,
   parameter int unsigned LANES = 1,
   parameter int unsigned TAG_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [LANES-1:0][QUO_W+DEN_W-1:0]  in_num,
   input  logic [DEN_W-1:0]                   in_den,
   input  logic [TAG_W-1:0]                   in_tag,
   output logic                               out_valid,
   output logic [LANES-1:0][QUO_W-1:0]        out_quo,
   output logic [TAG_W-1:0]                   out_tag
);

   logic [QUO_W:0]                   valid_ff;
   logic [LANES-1:0][DEN_W-1:0]      rem_ff  [QUO_W];
   logic [DEN_W-1:0]                 den_ff  [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]      low_ff  [QUO_W+1];
   logic [TAG_W-1:0]                 tag_ff  [QUO_W+1];
   logic [LANES-1:0][DEN_W:0]        trial   [QUO_W];
   logic [LANES-1:0]                 take    [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]      low_in  [QUO_W];
   logic [LANES-1:0][DEN_W-1:0]      rem_in  [QUO_W-1];

   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            trial[k][l]  = {rem_ff[k][l], low_ff[k][l][QUO_W-1]};
            take[k][l]   = (trial[k][l] >= {1'b0, den_ff[k]});
            low_in[k][l] = {low_ff[k][l][QUO_W-2:0], take[k][l]};
         end
      end
      for (int k = 0; k < QUO_W - 1; k++) begin
         for (int l = 0; l < LANES; l++) begin
            rem_in[k][l] = take[k][l] ? DEN_W'(trial[k][l] - {1'b0, den_ff[k]})
                                      : trial[k][l][DEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QUO_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= in_num[l][QUO_W +: DEN_W];
            low_ff[0][l] <= in_num[l][QUO_W-1:0];
         end
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
         for (int k = 0; k < QUO_W - 1; k++) begin
            rem_ff[k+1] <= rem_in[k];
            den_ff[k+1] <= den_ff[k];
         end
         for (int k = 0; k < QUO_W; k++) begin
            low_ff[k+1] <= low_in[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = low_ff[QUO_W];
   assign out_tag   = tag_ff[QUO_W];

endmodule

`default_nettype wire

@@ src/rbw_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with a side tag per beat.
// Gives the floor of the root. Self-contained.
`default_nettype none

module rbw_sqrt #(
   parameter int unsigned ROOT_W = 32,
   parameter int unsigned TAG_W  = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [TAG_W-1:0]      out_tag
);

   logic [ROOT_W:0]           valid_ff;
   logic [2*ROOT_W-1:0]       rad_ff  [ROOT_W];
   logic [ROOT_W:0]           rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]         root_ff [ROOT_W+1];
   logic [TAG_W-1:0]          tag_ff  [ROOT_W+1];
   logic [ROOT_W+2:0]         shifted [ROOT_W];
   logic [ROOT_W+2:0]         trial   [ROOT_W];
   logic                      take    [ROOT_W];
   logic [ROOT_W-1:0]         root_in [ROOT_W];
   logic [ROOT_W:0]           rem_in  [ROOT_W-1];

   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         shifted[k] = {rem_ff[k], rad_ff[k][2*ROOT_W-1 -: 2]};
         trial[k]   = {1'b0, root_ff[k], 2'b01};
         take[k]    = (shifted[k] >= trial[k]);
         root_in[k] = {root_ff[k][ROOT_W-2:0], take[k]};
      end
      for (int k = 0; k < ROOT_W - 1; k++) begin
         rem_in[k] = take[k] ? (ROOT_W+1)'(shifted[k] - trial[k]) : shifted[k][ROOT_W:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ROOT_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= in_rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         tag_ff[0]  <= in_tag;
         for (int k = 0; k < ROOT_W - 1; k++) begin
            rad_ff[k+1] <= rad_ff[k] << 2;
            rem_ff[k+1] <= rem_in[k];
         end
         for (int k = 0; k < ROOT_W; k++) begin
            root_ff[k+1] <= root_in[k];
            tag_ff[k+1]  <= tag_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_tag   = tag_ff[ROOT_W];

endmodule

`default_nettype wire

@@ src/reflecting_box_wall_thermostat.sv @@
// Top level of the reflecting box wall thermostat: registers, wall reflection and the
// rescaling datapath. Uses rbw_pkg, rbw_divider and rbw_sqrt.
//
// Each req beat carries one particle: position, displacement, velocity and mass.
// Each rsp beat carries the moved and reflected position, the new velocity and
// the wall hit flag, one rsp beat for every req beat, in order.
// The csr port writes the box sizes, the Boltzmann constant and the temperature;
// a write is taken in the cycle its enable is high and must happen with nothing in flight.
// The block takes one beat in every cycle while rsp is not stalled. A result on rsp has
// passed through the serial chain of the three front stages, the target speed divider,
// the two square roots, the multiply stage, the rescale divider and the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and req_stall
// rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with 1.0 in Q15.16.
`default_nettype none

module reflecting_box_wall_thermostat #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [rbw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rbw_pkg::CFG_W-1:0]             csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [rbw_pkg::POS_W-1:0]             req_pos_x,
   input  logic [rbw_pkg::POS_W-1:0]             req_pos_y,
   input  logic [rbw_pkg::POS_W-1:0]             req_pos_z,
   input  logic signed [rbw_pkg::MOVE_W-1:0]     req_move_x,
   input  logic signed [rbw_pkg::MOVE_W-1:0]     req_move_y,
   input  logic signed [rbw_pkg::MOVE_W-1:0]     req_move_z,
   input  logic signed [rbw_pkg::VEL_W-1:0]      req_vel_x,
   input  logic signed [rbw_pkg::VEL_W-1:0]      req_vel_y,
   input  logic signed [rbw_pkg::VEL_W-1:0]      req_vel_z,
   input  logic [rbw_pkg::MASS_W-1:0]            req_mass,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rbw_pkg::POS_W-1:0]             rsp_new_pos_x,
   output logic [rbw_pkg::POS_W-1:0]             rsp_new_pos_y,
   output logic [rbw_pkg::POS_W-1:0]             rsp_new_pos_z,
   output logic signed [rbw_pkg::VEL_W-1:0]      rsp_new_vel_x,
   output logic signed [rbw_pkg::VEL_W-1:0]      rsp_new_vel_y,
   output logic signed [rbw_pkg::VEL_W-1:0]      rsp_new_vel_z,
   output logic                                  rsp_wall_hit
);

   import rbw_pkg::*;

   localparam int unsigned C1_W      = POS_W + 2;
   localparam int unsigned C2_W      = POS_W + 3;
   localparam int unsigned QUO1_W    = P_W - 2;
   localparam int unsigned NUM1_W    = QUO1_W + MASS_W;
   localparam int unsigned OVF_SHIFT = P_W - 2 - FRAC_BITS;

   logic en;

   logic [AXES-1:0][CFG_W-1:0] box_size_ff;
   logic [CFG_W-1:0]           boltz_ff;
   logic [CFG_W-1:0]           temp_ff;

   logic [AXES-1:0][POS_W-1:0]  req_pos;
   logic [AXES-1:0][MOVE_W-1:0] req_move;
   logic [AXES-1:0][VEL_W-1:0]  req_vel;

   logic                        s1_valid_ff;
   logic [AXES-1:0][C1_W-1:0]   s1_c_ff, s1_c_in;
   logic [AXES-1:0]             s1_neg_ff, s1_neg_in;
   logic [AXES-1:0][VEL_W-1:0]  s1_mag_ff, s1_mag_in;
   logic [KT_W-1:0]             s1_kt_ff, s1_kt_in;
   logic [MASS_W-1:0]           s1_mass_ff;

   logic                        s2_valid_ff;
   logic [AXES-1:0][C2_W-1:0]   s2_c_ff, s2_c_in;
   logic [AXES-1:0]             s2_neg_ff, s2_neg_in;
   logic [AXES-1:0]             s2_flip;
   logic                        s2_hit_ff;
   logic [AXES-1:0][VEL_W-1:0]  s2_mag_ff;
   logic [AXES-1:0][SUM_W-1:0]  s2_sq_ff, s2_sq_in;
   logic [P_W-1:0]              s2_p_ff, s2_p_in;
   logic [MASS_W-1:0]           s2_mass_ff;

   logic                        s3_valid_ff;
   rbw_kin_type                 s3_kin_ff, s3_kin_in;
   logic [SUM_W-1:0]            s3_sum_ff, s3_sum_in;
   logic [P_W-1:0]              s3_p_ff;
   logic                        s3_sat_ff, s3_sat_in;
   logic [MASS_W-1:0]           s3_mass_ff;

   logic [0:0][NUM1_W-1:0]      d1_num;
   rbw_speed_tag_type           d1_tag_in, d1_tag;
   logic                        d1_valid;
   logic [0:0][QUO1_W-1:0]      d1_quo;

   logic                        sq_valid;
   logic [SPEED_W-1:0]          sq_root;
   rbw_speed_tag_type           sq_tag;
   rbw_len_tag_type             len_tag_in, len_tag;
   logic                        len_valid;
   logic [LEN_W-1:0]            len_root;

   logic                          m_valid_ff;
   logic [AXES-1:0][PROD_W-1:0]   m_prod_ff, m_prod_in;
   logic [LEN_W-2:0]              m_half_ff;
   logic [LEN_W-1:0]              m_len_ff;
   rbw_quot_tag_type              m_tag_ff, m_tag_in;

   logic [AXES-1:0][2*LEN_W-1:0]  d2_num;
   logic                          d2_valid;
   logic [AXES-1:0][LEN_W-1:0]    d2_quo;
   rbw_quot_tag_type              d2_tag;

   logic [AXES-1:0][VEL_W-1:0]    sel_mag;
   logic                          rsp_valid_ff;
   logic [AXES-1:0][POS_W-1:0]    rsp_pos_ff;
   logic [AXES-1:0][VEL_W-1:0]    rsp_vel_ff, rsp_vel_in;
   logic                          rsp_hit_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_size_ff <= {AXES{CFG_RESET}};
         boltz_ff    <= CFG_RESET;
         temp_ff     <= CFG_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BOX_SIZE_X:  box_size_ff[0] <= csr_data;
            CSR_BOX_SIZE_Y:  box_size_ff[1] <= csr_data;
            CSR_BOX_SIZE_Z:  box_size_ff[2] <= csr_data;
            CSR_BOLTZMANN:   boltz_ff       <= csr_data;
            CSR_TEMPERATURE: temp_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_pos  = {req_pos_z, req_pos_y, req_pos_x};
   assign req_move = {req_move_z, req_move_y, req_move_x};
   assign req_vel  = {req_vel_z, req_vel_y, req_vel_x};

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         s1_c_in[i]   = {2'b00, req_pos[i]} + {req_move[i][MOVE_W-1], req_move[i]};
         s1_neg_in[i] = req_vel[i][VEL_W-1];
         s1_mag_in[i] = s1_neg_in[i] ? (~req_vel[i] + 1'b1) : req_vel[i];
      end
      s1_kt_in = KT_W'(boltz_ff) * KT_W'(temp_ff);
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         if (s1_c_ff[i][C1_W-1]) begin
            s2_flip[i] = 1'b1;
            s2_c_in[i] = C2_W'(0) - {s1_c_ff[i][C1_W-1], s1_c_ff[i]};
         end else if (s1_c_ff[i] > {2'b00, box_size_ff[i]}) begin
            s2_flip[i] = 1'b1;
            s2_c_in[i] = {2'b00, box_size_ff[i], 1'b0} - {s1_c_ff[i][C1_W-1], s1_c_ff[i]};
         end else begin
            s2_flip[i] = 1'b0;
            s2_c_in[i] = {s1_c_ff[i][C1_W-1], s1_c_ff[i]};
         end
         s2_neg_in[i] = s1_neg_ff[i] ^ s2_flip[i];
         s2_sq_in[i]  = SUM_W'(s1_mag_ff[i]) * SUM_W'(s1_mag_ff[i]);
      end
      s2_p_in = P_W'(s1_kt_ff) + (P_W'(s1_kt_ff) << 1);
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         if (s2_c_ff[i][C2_W-1]) begin
            s3_kin_in.pos[i] = '0;
         end else if (s2_c_ff[i][C2_W-2:0] > {2'b00, box_size_ff[i]}) begin
            s3_kin_in.pos[i] = box_size_ff[i];
         end else begin
            s3_kin_in.pos[i] = s2_c_ff[i][POS_W-1:0];
         end
      end
      s3_kin_in.neg = s2_neg_ff;
      s3_kin_in.mag = s2_mag_ff;
      s3_kin_in.hit = s2_hit_ff;
      s3_sum_in     = s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
      s3_sat_in     = (s2_mass_ff == '0) || ((s2_p_ff >> OVF_SHIFT) >= P_W'(s2_mass_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         m_valid_ff  <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         m_valid_ff  <= len_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_c_ff    <= s1_c_in;
         s1_neg_ff  <= s1_neg_in;
         s1_mag_ff  <= s1_mag_in;
         s1_kt_ff   <= s1_kt_in;
         s1_mass_ff <= req_mass;
         s2_c_ff    <= s2_c_in;
         s2_neg_ff  <= s2_neg_in;
         s2_hit_ff  <= |s2_flip;
         s2_mag_ff  <= s1_mag_ff;
         s2_sq_ff   <= s2_sq_in;
         s2_p_ff    <= s2_p_in;
         s2_mass_ff <= s1_mass_ff;
         s3_kin_ff  <= s3_kin_in;
         s3_sum_ff  <= s3_sum_in;
         s3_p_ff    <= s2_p_ff;
         s3_sat_ff  <= s3_sat_in;
         s3_mass_ff <= s2_mass_ff;
      end
   end

   assign d1_num[0]     = NUM1_W'(s3_p_ff) << FRAC_BITS;
   assign d1_tag_in.kin = s3_kin_ff;
   assign d1_tag_in.sum = s3_sum_ff;
   assign d1_tag_in.sat = s3_sat_ff;

   rbw_divider #(
      .QUO_W (QUO1_W),
      .DEN_W (MASS_W),
      .LANES (1),
      .TAG_W ($bits(rbw_speed_tag_type))
   ) u_speed_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (d1_num),
      .in_den    (s3_mass_ff),
      .in_tag    (d1_tag_in),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_tag   (d1_tag)
   );

   rbw_sqrt #(
      .ROOT_W (SPEED_W),
      .TAG_W  ($bits(rbw_speed_tag_type))
   ) u_speed_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid),
      .in_rad    (d1_quo[0]),
      .in_tag    (d1_tag),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   assign len_tag_in.kin   = sq_tag.kin;
   assign len_tag_in.speed = sq_tag.sat ? SPEED_MAX : sq_root;

   rbw_sqrt #(
      .ROOT_W (LEN_W),
      .TAG_W  ($bits(rbw_len_tag_type))
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_rad    (sq_tag.sum),
      .in_tag    (len_tag_in),
      .out_valid (len_valid),
      .out_root  (len_root),
      .out_tag   (len_tag)
   );

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         m_prod_in[i] = PROD_W'(len_tag.kin.mag[i]) * PROD_W'(len_tag.speed);
      end
      m_tag_in.kin     = len_tag.kin;
      m_tag_in.rescale = len_tag.kin.hit && (len_root != '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_prod_ff <= m_prod_in;
         m_half_ff <= len_root[LEN_W-1:1];
         m_len_ff  <= len_root;
         m_tag_ff  <= m_tag_in;
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         d2_num[i] = (2*LEN_W)'(m_prod_ff[i]) + (2*LEN_W)'(m_half_ff);
      end
   end

   rbw_divider #(
      .QUO_W (LEN_W),
      .DEN_W (LEN_W),
      .LANES (AXES),
      .TAG_W ($bits(rbw_quot_tag_type))
   ) u_rescale_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid_ff),
      .in_num    (d2_num),
      .in_den    (m_len_ff),
      .in_tag    (m_tag_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_tag   (d2_tag)
   );

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sel_mag[i] = d2_tag.rescale ? d2_quo[i] : d2_tag.kin.mag[i];
         if (d2_tag.kin.neg[i]) begin
            rsp_vel_in[i] = (sel_mag[i] > VEL_MIN) ? VEL_MIN : (~sel_mag[i] + 1'b1);
         end else begin
            rsp_vel_in[i] = sel_mag[i][VEL_W-1] ? VEL_MAX : sel_mag[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_pos_ff <= d2_tag.kin.pos;
         rsp_vel_ff <= rsp_vel_in;
         rsp_hit_ff <= d2_tag.kin.hit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_pos_x = rsp_pos_ff[0];
   assign rsp_new_pos_y = rsp_pos_ff[1];
   assign rsp_new_pos_z = rsp_pos_ff[2];
   assign rsp_new_vel_x = rsp_vel_ff[0];
   assign rsp_new_vel_y = rsp_vel_ff[1];
   assign rsp_new_vel_z = rsp_vel_ff[2];
   assign rsp_wall_hit  = rsp_hit_ff;

   // No velocity component can exceed the length of the vector it belongs to.
   a_mag_within_len: assert property (@(posedge clock) disable iff (reset)
      len_valid |-> (len_tag.kin.mag[0] <= len_root) && (len_tag.kin.mag[1] <= len_root)
                    && (len_tag.kin.mag[2] <= len_root))
      else $error("velocity component exceeds the vector length");

   // A rescaled component never exceeds the target speed, so it stays in range.
   a_rescale_in_range: assert property (@(posedge clock) disable iff (reset)
      d2_valid && d2_tag.rescale |-> !d2_quo[0][LEN_W-1] && !d2_quo[1][LEN_W-1]
                                     && !d2_quo[2][LEN_W-1])
      else $error("rescaled velocity out of range");

endmodule

`default_nettype wire
